// ===== rtl/header_length_trailer_deframer_core_defines.svh =====
// assertion helpers for the deframer
`ifndef HEADER_LENGTH_TRAILER_DEFRAMER_CORE_DEFINES_SVH
`define HEADER_LENGTH_TRAILER_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication
`define HLTD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication
`define HLTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// ===== rtl/hltd_pkg.sv =====
`default_nettype none
package hltd_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

    localparam logic [7:0] HEADER_RESET  = 8'hAA;
    localparam logic [7:0] TRAILER_RESET = 8'hAF;

    localparam int PADDR_W = 3;
    localparam logic REG_HEADER  = 1'b0;
    localparam logic REG_TRAILER = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_CODE    = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_TRAILER = 3'd4,
        PH_DRAIN   = 3'd5
    } phase_t;

endpackage
`default_nettype wire

// ===== rtl/hltd_ram.sv =====
`default_nettype none
module hltd_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/header_length_trailer_deframer_core.sv =====
// a too-long or zero-length frame gives its result in the cycle after the deciding byte
// payload frames: after the trailer, each stored byte is read and then loaded as a result
// throughput: one received byte per cycle, paused while a stored frame is read out and,
// at length/trailer bytes, while a result waits; the single buffer read port is registered
// reset: rst_n clears parse state and output valid, config returns to 0xaa / 0xaf
`default_nettype none
`include "header_length_trailer_deframer_core_defines.svh"
module header_length_trailer_deframer_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hltd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [7:0]                    rx_byte,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [7:0]                    function_code,
    output logic      [7:0]                    payload_length,
    output logic      [5:0]                    byte_index,
    output logic      [7:0]                    payload_byte,
    output logic                               has_payload,
    output logic                               too_long,
    output logic                               last
);
    import hltd_pkg::*;

    logic [7:0]       header_byte_reg;
    logic [7:0]       trailer_byte_reg;
    phase_t           phase_reg, phase_next;
    logic [7:0]       held_code_reg, held_code_next;
    logic [7:0]       held_length_reg, held_length_next;
    logic [CNT_W-1:0] taken_reg, taken_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_pending_reg, rd_pending_next;
    logic             out_valid_reg;
    logic [7:0]       out_code_reg, out_length_reg, out_byte_reg;
    logic [5:0]       out_index_reg;
    logic             out_has_reg, out_too_reg, out_last_reg;

    logic             cfg_wr;
    logic             accept;
    logic             slot_free;
    logic             mem_we, mem_re;
    logic [7:0]       mem_q;
    logic             ld;
    logic [7:0]       ld_length;
    logic [5:0]       ld_index;
    logic [7:0]       ld_byte;
    logic             ld_has, ld_too, ld_last;

    // apb config
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb
    begin
        case (paddr[2])
            REG_HEADER:  prdata = {24'd0, header_byte_reg};
            REG_TRAILER: prdata = {24'd0, trailer_byte_reg};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_byte_reg  <= HEADER_RESET;
            trailer_byte_reg <= TRAILER_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_HEADER)
            begin
                header_byte_reg <= pwdata[7:0];
            end
            else
            begin
                trailer_byte_reg <= pwdata[7:0];
            end
        end
    end

    // handshakes
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (phase_reg != PH_DRAIN)
                       && (slot_free || !(phase_reg inside {PH_LENGTH, PH_TRAILER}));
    assign accept    = in_valid && in_ready;

    hltd_ram #(
        .DEPTH (BUFFER_DEPTH),
        .WIDTH (8)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (taken_reg[ADDR_W-1:0]),
        .wdata (rx_byte),
        .re    (mem_re),
        .raddr (rd_idx_reg[ADDR_W-1:0]),
        .rdata (mem_q)
    );

    // parser and read-out sequencer
    always_comb
    begin
        phase_next       = phase_reg;
        held_code_next   = held_code_reg;
        held_length_next = held_length_reg;
        taken_next       = taken_reg;
        rd_idx_next      = rd_idx_reg;
        rd_pending_next  = rd_pending_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        ld               = 1'b0;
        ld_length        = held_length_reg;
        ld_index         = 6'd0;
        ld_byte          = 8'd0;
        ld_has           = 1'b0;
        ld_too           = 1'b0;
        ld_last          = 1'b1;
        case (phase_reg)
            PH_CODE:
            begin
                if (accept)
                begin
                    held_code_next = rx_byte;
                    phase_next     = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                if (accept)
                begin
                    held_length_next = rx_byte;
                    taken_next       = '0;
                    if (rx_byte > 8'(BUFFER_DEPTH))
                    begin
                        ld         = 1'b1;
                        ld_length  = rx_byte;
                        ld_too     = 1'b1;
                        phase_next = PH_HEADER;
                    end
                    else if (rx_byte == 8'd0)
                    begin
                        phase_next = PH_TRAILER;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (accept)
                begin
                    mem_we     = 1'b1;
                    taken_next = taken_reg + CNT_W'(1);
                    if ((8'(taken_reg) + 8'd1) >= held_length_reg)
                    begin
                        phase_next = PH_TRAILER;
                    end
                end
            end
            PH_TRAILER:
            begin
                if (accept)
                begin
                    if ((rx_byte == trailer_byte_reg) && (held_length_reg != 8'd0))
                    begin
                        phase_next      = PH_DRAIN;
                        rd_idx_next     = '0;
                        rd_pending_next = 1'b0;
                    end
                    else
                    begin
                        ld               = (rx_byte == trailer_byte_reg);
                        phase_next       = PH_HEADER;
                        held_code_next   = 8'd0;
                        held_length_next = 8'd0;
                        taken_next       = '0;
                    end
                end
            end
            PH_DRAIN:
            begin
                if (!rd_pending_reg)
                begin
                    mem_re          = 1'b1;
                    rd_pending_next = 1'b1;
                end
                else if (slot_free)
                begin
                    ld              = 1'b1;
                    ld_index        = 6'(rd_idx_reg);
                    ld_byte         = mem_q;
                    ld_has          = 1'b1;
                    ld_last         = ((8'(rd_idx_reg) + 8'd1) == held_length_reg);
                    rd_pending_next = 1'b0;
                    rd_idx_next     = rd_idx_reg + CNT_W'(1);
                    if (ld_last)
                    begin
                        phase_next       = PH_HEADER;
                        held_code_next   = 8'd0;
                        held_length_next = 8'd0;
                        taken_next       = '0;
                    end
                end
            end
            default:
            begin
                if (accept)
                begin
                    phase_next = (rx_byte == header_byte_reg) ? PH_CODE : PH_HEADER;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            held_code_reg   <= 8'd0;
            held_length_reg <= 8'd0;
            taken_reg       <= '0;
            rd_idx_reg      <= '0;
            rd_pending_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            held_code_reg   <= held_code_next;
            held_length_reg <= held_length_next;
            taken_reg       <= taken_next;
            rd_idx_reg      <= rd_idx_next;
            rd_pending_reg  <= rd_pending_next;
            if (ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            out_code_reg   <= held_code_reg;
            out_length_reg <= ld_length;
            out_index_reg  <= ld_index;
            out_byte_reg   <= ld_byte;
            out_has_reg    <= ld_has;
            out_too_reg    <= ld_too;
            out_last_reg   <= ld_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign function_code  = out_code_reg;
    assign payload_length = out_length_reg;
    assign byte_index     = out_index_reg;
    assign payload_byte   = out_byte_reg;
    assign has_payload    = out_has_reg;
    assign too_long       = out_too_reg;
    assign last           = out_last_reg;

    `HLTD_ASSERT_SAME(a_no_input_in_drain, phase_reg == PH_DRAIN, !in_ready)
    `HLTD_ASSERT_SAME(a_load_needs_slot, ld, slot_free)
    `HLTD_ASSERT_NEXT(a_read_then_pending, mem_re, rd_pending_reg)
    `HLTD_ASSERT_SAME(a_too_long_no_payload, out_valid_reg, !(out_too_reg && out_has_reg))
    `HLTD_ASSERT_SAME(a_index_in_frame, out_valid_reg && out_has_reg,
                      {2'b00, out_index_reg} < out_length_reg)

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

    import hltd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_LIMIT = 4000;

    typedef struct packed {
        logic [7:0] code;
        logic [7:0] len;
        logic [5:0] idx;
        logic [7:0] data;
        logic       has_data;
        logic       over;
        logic       last;
    } frame_rec_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       fixed;
        frame_rec_t want;
    } row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [7:0]          rx_byte = 8'h00;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [7:0]          function_code;
    logic [7:0]          payload_length;
    logic [5:0]          byte_index;
    logic [7:0]          payload_byte;
    logic                has_payload;
    logic                too_long;
    logic                last;

    // mirror of the deframer
    logic [7:0]          hdr_cfg = HEADER_RESET;
    logic [7:0]          trl_cfg = TRAILER_RESET;
    phase_t              parse_ph = PH_HEADER;
    logic [7:0]          held_code = 8'h00;
    logic [7:0]          held_len = 8'h00;
    logic [7:0]          taken = 8'h00;
    logic [7:0]          frame_store [BUFFER_DEPTH];

    frame_rec_t          due_recs [$];
    bit                  src_calm = 1'b1;
    bit                  snk_calm = 1'b1;
    int unsigned         mismatches = 0;
    int unsigned         bytes_sent = 0;
    int unsigned         recs_seen = 0;
    int unsigned         frames_closed = 0;
    int unsigned         over_flags = 0;
    int unsigned         cycle_count = 0;

    always #10 clk = ~clk;

    header_length_trailer_deframer_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .function_code  (function_code),
        .payload_length (payload_length),
        .byte_index     (byte_index),
        .payload_byte   (payload_byte),
        .has_payload    (has_payload),
        .too_long       (too_long),
        .last           (last)
    );

    function automatic frame_rec_t frame_rec(input logic [5:0] idx, input logic [7:0] data,
                                             input logic has_data, input logic over,
                                             input logic fin);
        frame_rec_t r;
        r = '{held_code, held_len, idx, data, has_data, over, fin};
        return r;
    endfunction

    task automatic parse_rx_byte(input logic [7:0] b, input bit keep);
        int unsigned k;
        case (parse_ph)
            PH_CODE:
            begin
                held_code = b;
                parse_ph = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                held_len = b;
                taken = 8'h00;
                if (b > 8'(BUFFER_DEPTH))
                begin
                    if (keep)
                    begin
                        due_recs.push_back(frame_rec(6'd0, 8'h00, 1'b0, 1'b1, 1'b1));
                    end
                    parse_ph = PH_HEADER;
                end
                else if (b == 8'h00)
                begin
                    parse_ph = PH_TRAILER;
                end
                else
                begin
                    parse_ph = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                frame_store[taken[ADDR_W-1:0]] = b;
                taken = taken + 8'd1;
                if (taken >= held_len)
                begin
                    parse_ph = PH_TRAILER;
                end
            end
            PH_TRAILER:
            begin
                if (b == trl_cfg && keep)
                begin
                    if (held_len == 8'h00)
                    begin
                        due_recs.push_back(frame_rec(6'd0, 8'h00, 1'b0, 1'b0, 1'b1));
                    end
                    else
                    begin
                        for (k = 0; k < 32'(held_len); k++)
                        begin
                            due_recs.push_back(frame_rec(6'(k), frame_store[k[ADDR_W-1:0]],
                                                         1'b1, 1'b0,
                                                         (k + 1) == 32'(held_len)));
                        end
                    end
                end
                parse_ph = PH_HEADER;
                held_code = 8'h00;
                held_len = 8'h00;
                taken = 8'h00;
            end
            default:
            begin
                parse_ph = (b == hdr_cfg) ? PH_CODE : PH_HEADER;
            end
        endcase
    endtask

    function automatic row_t row(input logic [7:0] b, input logic fixed = 1'b0,
                                 input logic [7:0] c = 8'h00, input logic [7:0] l = 8'h00,
                                 input logic over = 1'b0);
        row_t r;
        r.rx = b;
        r.fixed = fixed;
        r.want = '{c, l, 6'd0, 8'h00, 1'b0, over, 1'b1};
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fixed = 1'b0,
                             input frame_rec_t want = '0);
        int unsigned gap;
        gap = src_calm ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (!in_ready);
        parse_rx_byte(b, !fixed);
        if (fixed)
        begin
            due_recs.push_back(want);
        end
        bytes_sent++;
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_HEADER)
        begin
            hdr_cfg = v;
        end
        else
        begin
            trl_cfg = v;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle(input int unsigned quiet_cycles);
        int unsigned guard;
        guard = 0;
        while (due_recs.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (quiet_cycles) @(posedge clk);
    endtask

    task automatic random_traffic(input int unsigned budget);
        int unsigned start;
        int unsigned kind;
        int unsigned pick;
        int unsigned len;
        int unsigned cut;
        int unsigned k;
        logic [7:0]  v;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            kind = $urandom_range(0, 99);
            src_calm = ($urandom_range(0, 3) == 0);
            snk_calm = ($urandom_range(0, 3) == 0);
            if (kind < 10)
            begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    len = $urandom_range(0, 6);
                else if (pick < 72)
                    len = $urandom_range(7, 24);
                else if (pick < 80)
                    len = $urandom_range(25, BUFFER_DEPTH - 1);
                else if (pick < 86)
                    len = BUFFER_DEPTH;
                else
                    len = $urandom_range(BUFFER_DEPTH + 1, 255);
                send_byte(hdr_cfg);
                send_byte(8'($urandom));
                send_byte(8'(len));
                if (len <= BUFFER_DEPTH)
                begin
                    // truncated frames leave the parser out of step on purpose
                    cut = (kind < 18) ? $urandom_range(0, len) : len;
                    for (k = 0; k < cut; k++)
                    begin
                        send_byte(8'($urandom));
                    end
                    if (cut == len)
                    begin
                        v = trl_cfg;
                        if (kind < 28)
                        begin
                            v = trl_cfg ^ 8'($urandom_range(1, 255));
                        end
                        send_byte(v);
                    end
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result side
    initial
    begin
        frame_rec_t got;
        frame_rec_t want;
        int unsigned hold;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            hold = snk_calm ? 0 : $urandom_range(0, 15);
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got = '{function_code, payload_length, byte_index, payload_byte,
                    has_payload, too_long, last};
            recs_seen++;
            frames_closed += got.last;
            over_flags += got.over;
            if (due_recs.size() == 0)
            begin
                $display("%0t ns: transaction with nothing expected, actual %p", $time, got);
                mismatches++;
            end
            else
            begin
                want = due_recs.pop_front();
                check_field("function_code", want.code, got.code);
                check_field("payload_length", want.len, got.len);
                check_field("byte_index", 8'(want.idx), 8'(got.idx));
                check_field("payload_byte", want.data, got.data);
                check_field("has_payload", 8'(want.has_data), 8'(got.has_data));
                check_field("too_long", 8'(want.over), 8'(got.over));
                check_field("last", 8'(want.last), 8'(got.last));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        row_t        script [$];
        logic [7:0]  h;
        logic [7:0]  t;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero length, too long at both ends, header right after a too-long flag
        script.push_back(row(8'hAA));
        script.push_back(row(8'h12));
        script.push_back(row(8'h00));
        script.push_back(row(8'hAF, 1'b1, 8'h12, 8'h00, 1'b0));
        script.push_back(row(8'hAA));
        script.push_back(row(8'hFF));
        script.push_back(row(8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1));
        script.push_back(row(8'hAA));
        script.push_back(row(8'h34));
        script.push_back(row(8'h41, 1'b1, 8'h34, 8'h41, 1'b1));
        script.push_back(row(8'hAA));
        script.push_back(row(8'h01));
        script.push_back(row(8'h02));
        script.push_back(row(8'hFF));
        script.push_back(row(8'h00));
        script.push_back(row(8'hAF));
        // wrong trailers drop the frame
        script.push_back(row(8'hAA));
        script.push_back(row(8'h05));
        script.push_back(row(8'h01));
        script.push_back(row(8'h5A));
        script.push_back(row(8'h00));
        script.push_back(row(8'hAA));
        script.push_back(row(8'h00));
        script.push_back(row(8'h00));
        script.push_back(row(8'h00));
        foreach (script[i])
        begin
            send_byte(script[i].rx, script[i].fixed, script[i].want);
        end
        in_valid <= 1'b0;
        settle(8);

        for (int p = 0; p < 4; p++)
        begin
            h = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : (p == 2) ? HEADER_RESET : 8'($urandom);
            t = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : (p == 2) ? TRAILER_RESET : 8'($urandom);
            write_reg(REG_HEADER, h);
            write_reg(REG_TRAILER, t);
            random_traffic(100);
            in_valid <= 1'b0;
            settle(8);
        end

        if (due_recs.size() != 0)
        begin
            $display("%0t ns: %0d expected transactions never arrived, first %p",
                     $time, due_recs.size(), due_recs[0]);
            mismatches += due_recs.size();
        end
        $display("sent %0d bytes under five header/trailer settings incl. 00/ff extremes",
                 bytes_sent);
        $display("checked %0d results: %0d frames closed, %0d too-long flags",
                 recs_seen, frames_closed, over_flags);
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
